// File: src/assert_macros.svh
// Assertion macros shared by the inverse affine clip box RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IACB_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define IACB_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: src/iacb_pkg.sv
// Package for the inverse affine clip box block: queue depth and queue status type.
// No dependencies.
package iacb_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = 2;
    localparam int QUEUE_CNT_BITS = 3;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

// File: src/inverse_affine_clip_bbox.sv
// Top level of the inverse affine clip box block: front, queue and back parts.
// Depends on iacb_pkg, iacb_front, iacb_queue and iacb_back.
//
//  channel  direction  handshake            payload
//  s_       in         s_valid / s_ready    matrix a..f, clip rectangle (signed fixed point)
//  m_       out        m_valid / m_ready    user box min/max, singular, saturated
//
// One item enters per cycle and one result leaves per cycle in steady state while m_ready stays high.
// Items pass through four front stages (products, sums), the queue, WORD_BITS + 3
// divider stages (one quotient bit in each of WORD_BITS of them) and the output
// register. Reset (aresetn low, synchronous) empties the pipelines and the queue.
// A stall on m_ready holds the back part; the front keeps accepting until the
// four-entry queue fills, then s_ready drops.
module inverse_affine_clip_bbox #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [WORD_BITS-1:0] s_m_a,
    input  logic signed [WORD_BITS-1:0] s_m_b,
    input  logic signed [WORD_BITS-1:0] s_m_c,
    input  logic signed [WORD_BITS-1:0] s_m_d,
    input  logic signed [WORD_BITS-1:0] s_m_e,
    input  logic signed [WORD_BITS-1:0] s_m_f,
    input  logic signed [WORD_BITS-1:0] s_clip_x_min,
    input  logic signed [WORD_BITS-1:0] s_clip_y_min,
    input  logic signed [WORD_BITS-1:0] s_clip_x_max,
    input  logic signed [WORD_BITS-1:0] s_clip_y_max,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [WORD_BITS-1:0] m_user_x_min,
    output logic signed [WORD_BITS-1:0] m_user_y_min,
    output logic signed [WORD_BITS-1:0] m_user_x_max,
    output logic signed [WORD_BITS-1:0] m_user_y_max,
    output logic                        m_singular,
    output logic                        m_saturated
);
    import iacb_pkg::*;

    localparam int SW = 2 * WORD_BITS + 1;
    localparam int NW = 2 * WORD_BITS + 2;
    localparam int EW = 8 * NW + SW;

    queue_stat_t q_stat;
    logic        push, pop;
    logic [EW-1:0] q_wdata, q_rdata;

    logic signed [SW-1:0] f_det, b_det;
    logic signed [NW-1:0] f_nx [4];
    logic signed [NW-1:0] f_ny [4];
    logic signed [NW-1:0] b_nx [4];
    logic signed [NW-1:0] b_ny [4];

    iacb_front #(.WORD_BITS(WORD_BITS)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .m_a        (s_m_a),
        .m_b        (s_m_b),
        .m_c        (s_m_c),
        .m_d        (s_m_d),
        .m_e        (s_m_e),
        .m_f        (s_m_f),
        .clip_x_min (s_clip_x_min),
        .clip_y_min (s_clip_y_min),
        .clip_x_max (s_clip_x_max),
        .clip_y_max (s_clip_y_max),
        .q_stat     (q_stat),
        .push       (push),
        .det        (f_det),
        .num_x      (f_nx),
        .num_y      (f_ny)
    );

    // pack determinant and numerators into one queue entry
    always_comb begin
        q_wdata = '0;
        for (int k = 0; k < 4; k++) begin
            q_wdata[k*NW +: NW]     = f_nx[k];
            q_wdata[(4+k)*NW +: NW] = f_ny[k];
        end
        q_wdata[8*NW +: SW] = f_det;
    end

    iacb_queue #(.DATA_BITS(EW)) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wdata   (q_wdata),
        .pop     (pop),
        .rdata   (q_rdata),
        .stat    (q_stat)
    );

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            b_nx[k] = q_rdata[k*NW +: NW];
            b_ny[k] = q_rdata[(4+k)*NW +: NW];
        end
        b_det = q_rdata[8*NW +: SW];
    end

    iacb_back #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_stat    (q_stat),
        .pop       (pop),
        .det       (b_det),
        .num_x     (b_nx),
        .num_y     (b_ny),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .x_min     (m_user_x_min),
        .y_min     (m_user_y_min),
        .x_max     (m_user_x_max),
        .y_max     (m_user_y_max),
        .singular  (m_singular),
        .saturated (m_saturated)
    );

endmodule

// File: src/iacb_front.sv
// Front part: accepts items, forms the determinant and the eight corner numerators.
// Depends on iacb_pkg.
module iacb_front #(
    parameter int WORD_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [WORD_BITS-1:0]   m_a,
    input  logic signed [WORD_BITS-1:0]   m_b,
    input  logic signed [WORD_BITS-1:0]   m_c,
    input  logic signed [WORD_BITS-1:0]   m_d,
    input  logic signed [WORD_BITS-1:0]   m_e,
    input  logic signed [WORD_BITS-1:0]   m_f,
    input  logic signed [WORD_BITS-1:0]   clip_x_min,
    input  logic signed [WORD_BITS-1:0]   clip_y_min,
    input  logic signed [WORD_BITS-1:0]   clip_x_max,
    input  logic signed [WORD_BITS-1:0]   clip_y_max,
    input  iacb_pkg::queue_stat_t         q_stat,
    output logic                          push,
    output logic signed [2*WORD_BITS:0]   det,
    output logic signed [2*WORD_BITS+1:0] num_x [4],
    output logic signed [2*WORD_BITS+1:0] num_y [4]
);
    import iacb_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int PW = 2 * W;
    localparam int SW = PW + 1;
    localparam int NW = PW + 2;

    logic adv;
    logic va_reg, vb_reg, vc_reg, vd_reg;

    logic signed [W-1:0] a_reg, b_reg, c_reg, d_reg, e_reg, f_reg;
    logic signed [W-1:0] x_reg [2];
    logic signed [W-1:0] y_reg [2];

    logic signed [PW-1:0] ad_reg, bc_reg, cf_reg, de_reg, be_reg, af_reg;
    logic signed [PW-1:0] xd_reg [2];
    logic signed [PW-1:0] xb_reg [2];
    logic signed [PW-1:0] yc_reg [2];
    logic signed [PW-1:0] ya_reg [2];

    logic signed [SW-1:0] detc_reg, xoff_reg, yoff_reg;
    logic signed [SW-1:0] px_reg [4];
    logic signed [SW-1:0] py_reg [4];

    logic signed [SW-1:0] detd_reg;
    logic signed [NW-1:0] nx_reg [4];
    logic signed [NW-1:0] ny_reg [4];

    // hold the whole pipeline while the queue is full
    assign adv      = !q_stat.full;
    assign in_ready = adv;
    assign push     = vd_reg && adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end else if (adv) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_reg    <= m_a;
            b_reg    <= m_b;
            c_reg    <= m_c;
            d_reg    <= m_d;
            e_reg    <= m_e;
            f_reg    <= m_f;
            x_reg[0] <= clip_x_min;
            x_reg[1] <= clip_x_max;
            y_reg[0] <= clip_y_min;
            y_reg[1] <= clip_y_max;

            ad_reg <= a_reg * d_reg;
            bc_reg <= b_reg * c_reg;
            cf_reg <= c_reg * f_reg;
            de_reg <= d_reg * e_reg;
            be_reg <= b_reg * e_reg;
            af_reg <= a_reg * f_reg;
            for (int i = 0; i < 2; i++) begin
                xd_reg[i] <= x_reg[i] * d_reg;
                xb_reg[i] <= x_reg[i] * b_reg;
                yc_reg[i] <= y_reg[i] * c_reg;
                ya_reg[i] <= y_reg[i] * a_reg;
            end

            detc_reg <= SW'(ad_reg) - SW'(bc_reg);
            xoff_reg <= SW'(cf_reg) - SW'(de_reg);
            yoff_reg <= SW'(be_reg) - SW'(af_reg);
            for (int k = 0; k < 4; k++) begin
                px_reg[k] <= SW'(xd_reg[k/2]) - SW'(yc_reg[k%2]);
                py_reg[k] <= SW'(ya_reg[k%2]) - SW'(xb_reg[k/2]);
            end

            detd_reg <= detc_reg;
            for (int k = 0; k < 4; k++) begin
                nx_reg[k] <= NW'(px_reg[k]) + NW'(xoff_reg);
                ny_reg[k] <= NW'(py_reg[k]) + NW'(yoff_reg);
            end
        end
    end

    assign det   = detd_reg;
    assign num_x = nx_reg;
    assign num_y = ny_reg;

endmodule

// File: src/iacb_queue.sv
// Short register queue between the front and back parts.
// Depends on iacb_pkg and assert_macros.svh.
`include "assert_macros.svh"
module iacb_queue #(
    parameter int DATA_BITS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  logic [DATA_BITS-1:0]  wdata,
    input  logic                  pop,
    output logic [DATA_BITS-1:0]  rdata,
    output iacb_pkg::queue_stat_t stat
);
    import iacb_pkg::*;

    logic [DATA_BITS-1:0]      mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CNT_BITS-1:0] count_reg, count_next;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata      = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

    `IACB_ASSERT_IMP(a_no_overrun, aclk, aresetn, stat.full, !push)
    `IACB_ASSERT_IMP(a_no_underrun, aclk, aresetn, stat.empty, !pop)
endmodule

// File: src/iacb_div.sv
// One pipelined divider lane: rounds num * 2^FRAC_BITS / den to nearest and saturates.
// No dependencies.
module iacb_div #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic signed [2*WORD_BITS+1:0] num,
    input  logic signed [2*WORD_BITS:0]   den,
    output logic signed [WORD_BITS-1:0]   quo,
    output logic                          sat
);
    localparam int W   = WORD_BITS;
    localparam int SW  = 2 * W + 1;
    localparam int NW  = 2 * W + 2;
    localparam int XW  = NW + FRAC_BITS;
    localparam int CW0 = (XW > 3 * W + 1) ? XW : 3 * W + 1;
    localparam int CW  = CW0 + 1;
    localparam int LS  = W + 1;

    logic [CW-1:0] rem_reg [LS+1];
    logic [SW-1:0] d_reg   [LS+1];
    logic          neg_reg [LS+1];
    logic          ovf_reg [LS+1];
    logic [W-1:0]  q_reg   [LS+1];

    logic [NW-1:0] num_mag;
    logic [SW-1:0] den_mag;
    logic          rnd;
    logic [W:0]    qr;
    logic [W:0]    half;
    logic          sat_c;
    logic [W-1:0]  quo_c;
    logic signed [W-1:0] quo_reg;
    logic          sat_reg;

    assign num_mag = num[NW-1] ? NW'(-num) : NW'(num);
    assign den_mag = den[SW-1] ? SW'(-den) : SW'(den);

    // stage 0: magnitudes and scaled dividend
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= CW'(num_mag) << FRAC_BITS;
            d_reg[0]   <= den_mag;
            neg_reg[0] <= num[NW-1] ^ den[SW-1];
        end
    end

    // stage 1: a quotient of 2^W or more always clamps
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[1] <= rem_reg[0];
            d_reg[1]   <= d_reg[0];
            neg_reg[1] <= neg_reg[0];
            ovf_reg[1] <= rem_reg[0] >= (CW'(d_reg[0]) << W);
            q_reg[1]   <= '0;
        end
    end

    // one restoring step per stage, most significant quotient bit first
    for (genvar k = 0; k < W; k++) begin : g_step
        localparam int SH = W - 1 - k;
        logic [CW-1:0] trial;
        assign trial = CW'(d_reg[k+1]) << SH;
        always_ff @(posedge aclk) begin
            if (en) begin
                d_reg[k+2]   <= d_reg[k+1];
                neg_reg[k+2] <= neg_reg[k+1];
                ovf_reg[k+2] <= ovf_reg[k+1];
                if (rem_reg[k+1] >= trial) begin
                    rem_reg[k+2]   <= rem_reg[k+1] - trial;
                    q_reg[k+2]     <= q_reg[k+1] | (W'(1) << SH);
                end else begin
                    rem_reg[k+2]   <= rem_reg[k+1];
                    q_reg[k+2]     <= q_reg[k+1];
                end
            end
        end
    end

    // final stage: round half away from zero, then clamp
    always_comb begin
        half  = (W + 1)'(1) << (W - 1);
        rnd   = {rem_reg[LS], 1'b0} >= (CW + 1)'(d_reg[LS]);
        qr    = {1'b0, q_reg[LS]} + (W + 1)'(rnd);
        sat_c = ovf_reg[LS] || (neg_reg[LS] ? (qr > half) : (qr >= half));
        if (sat_c) begin
            quo_c = neg_reg[LS] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
            quo_c = neg_reg[LS] ? (~qr[W-1:0] + 1'b1) : qr[W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quo_reg <= quo_c;
            sat_reg <= sat_c;
        end
    end

    assign quo = quo_reg;
    assign sat = sat_reg;

endmodule

// File: src/iacb_back.sv
// Back part: eight divider lanes, bounding box of the corners and the output register.
// Depends on iacb_pkg, iacb_div and assert_macros.svh.
`include "assert_macros.svh"
module iacb_back #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  iacb_pkg::queue_stat_t         q_stat,
    output logic                          pop,
    input  logic signed [2*WORD_BITS:0]   det,
    input  logic signed [2*WORD_BITS+1:0] num_x [4],
    input  logic signed [2*WORD_BITS+1:0] num_y [4],
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [WORD_BITS-1:0]   x_min,
    output logic signed [WORD_BITS-1:0]   y_min,
    output logic signed [WORD_BITS-1:0]   x_max,
    output logic signed [WORD_BITS-1:0]   y_max,
    output logic                          singular,
    output logic                          saturated
);
    import iacb_pkg::*;

    localparam int W = WORD_BITS;
    localparam int L = W + 3;

    logic         adv;
    logic         in_valid;
    logic [L-1:0] vld_reg;
    logic [L-1:0] sing_reg;

    logic signed [W-1:0] xq [4];
    logic signed [W-1:0] yq [4];
    logic [7:0]          lane_sat;

    logic signed [W-1:0] xa, xb, xn, xc, xd, xx;
    logic signed [W-1:0] ya, yb, yn, yc, yd, yx;

    logic                out_valid_reg;
    logic signed [W-1:0] x_min_reg, y_min_reg, x_max_reg, y_max_reg;
    logic                singular_reg, saturated_reg;

    // advance the whole back pipeline whenever the output register can move
    assign adv      = !out_valid_reg || out_ready;
    assign in_valid = !q_stat.empty;
    assign pop      = adv && in_valid;

    for (genvar k = 0; k < 4; k++) begin : g_lane
        iacb_div #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_div_x (
            .aclk (aclk),
            .en   (adv),
            .num  (num_x[k]),
            .den  (det),
            .quo  (xq[k]),
            .sat  (lane_sat[k])
        );
        iacb_div #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_div_y (
            .aclk (aclk),
            .en   (adv),
            .num  (num_y[k]),
            .den  (det),
            .quo  (yq[k]),
            .sat  (lane_sat[4+k])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[L-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sing_reg <= {sing_reg[L-2:0], (det == '0)};
        end
    end

    always_comb begin
        xa = (xq[0] < xq[1]) ? xq[0] : xq[1];
        xb = (xq[2] < xq[3]) ? xq[2] : xq[3];
        xn = (xa < xb) ? xa : xb;
        xc = (xq[0] > xq[1]) ? xq[0] : xq[1];
        xd = (xq[2] > xq[3]) ? xq[2] : xq[3];
        xx = (xc > xd) ? xc : xd;
        ya = (yq[0] < yq[1]) ? yq[0] : yq[1];
        yb = (yq[2] < yq[3]) ? yq[2] : yq[3];
        yn = (ya < yb) ? ya : yb;
        yc = (yq[0] > yq[1]) ? yq[0] : yq[1];
        yd = (yq[2] > yq[3]) ? yq[2] : yq[3];
        yx = (yc > yd) ? yc : yd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= vld_reg[L-1];
        end
    end

    // drop the lane results on a zero determinant
    always_ff @(posedge aclk) begin
        if (adv) begin
            if (sing_reg[L-1]) begin
                x_min_reg     <= '0;
                y_min_reg     <= '0;
                x_max_reg     <= '0;
                y_max_reg     <= '0;
                singular_reg  <= 1'b1;
                saturated_reg <= 1'b0;
            end else begin
                x_min_reg     <= xn;
                y_min_reg     <= yn;
                x_max_reg     <= xx;
                y_max_reg     <= yx;
                singular_reg  <= 1'b0;
                saturated_reg <= |lane_sat;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign x_min     = x_min_reg;
    assign y_min     = y_min_reg;
    assign x_max     = x_max_reg;
    assign y_max     = y_max_reg;
    assign singular  = singular_reg;
    assign saturated = saturated_reg;

    `IACB_ASSERT_NXT(a_fill_out, aclk, aresetn, adv && vld_reg[L-1], out_valid_reg)
    `IACB_ASSERT_IMP(a_sing_zero, aclk, aresetn, out_valid_reg && singular_reg,
        x_min_reg == '0 && x_max_reg == '0 && y_min_reg == '0 && y_max_reg == '0 && !saturated_reg)
endmodule

// File: test/tb_inverse_affine_clip_bbox.sv
// Testbench for inverse_affine_clip_bbox: directed and random items with a scoreboard.
// Depends on the block's RTL only; the box predictor is exact wide integer arithmetic.
`timescale 1ns / 1ps

typedef struct {
    logic signed [31:0] a, b, c, d, e, f;
    logic signed [31:0] x0, y0, x1, y1;
} affine_item_t;

typedef struct {
    logic signed [31:0] x_min, y_min, x_max, y_max;
    logic               singular, saturated;
} user_box_t;

class bbox_scoreboard;
    localparam int FRAC = 16;
    user_box_t pending_boxes[$];
    int        mismatches = 0;

    task report(string what, logic signed [31:0] got, logic signed [31:0] want);
        $display("%0t: %s got %0d want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Round num * 2^FRAC / den to nearest, ties away from zero, then clamp.
    function logic signed [31:0] round_corner(logic signed [127:0] num,
                                              logic [127:0] den, inout bit sat);
        logic [127:0] mag, q, r, lim;
        bit           neg;
        neg = num < 0;
        mag = neg ? -num : num;
        mag = mag << FRAC;
        q = mag / den;
        r = mag % den;
        if ((r << 1) >= den) q = q + 1;
        lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        if (q > lim) begin
            q = lim;
            sat = 1;
        end
        if (neg) q = -q;
        return q[31:0];
    endfunction

    function void note_item(affine_item_t it);
        logic signed [127:0] a, b, c, d, e, f, det, nx, ny;
        logic signed [127:0] xs[2], ys[2];
        logic signed [31:0]  vx, vy;
        logic [127:0]        den;
        user_box_t           box;
        bit                  sat;
        a = it.a; b = it.b; c = it.c; d = it.d; e = it.e; f = it.f;
        xs[0] = it.x0; xs[1] = it.x1; ys[0] = it.y0; ys[1] = it.y1;
        det = a * d - b * c;
        box = '{default: 0};
        if (det == 0) begin
            box.singular = 1;
            pending_boxes.push_back(box);
            return;
        end
        den = (det < 0) ? -det : det;
        sat = 0;
        for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 2; j++) begin
                nx = xs[i] * d - ys[j] * c + c * f - d * e;
                ny = ys[j] * a - xs[i] * b + b * e - a * f;
                if (det < 0) begin
                    nx = -nx;
                    ny = -ny;
                end
                vx = round_corner(nx, den, sat);
                vy = round_corner(ny, den, sat);
                if (i == 0 && j == 0) begin
                    box.x_min = vx; box.x_max = vx; box.y_min = vy; box.y_max = vy;
                end else begin
                    if (vx < box.x_min) box.x_min = vx;
                    if (vx > box.x_max) box.x_max = vx;
                    if (vy < box.y_min) box.y_min = vy;
                    if (vy > box.y_max) box.y_max = vy;
                end
            end
        end
        box.saturated = sat;
        pending_boxes.push_back(box);
    endfunction

    task check_result(user_box_t got);
        user_box_t want;
        if (pending_boxes.size() == 0) begin
            report("unexpected result, x_min", got.x_min, 0);
            return;
        end
        want = pending_boxes.pop_front();
        if (got.x_min !== want.x_min) report("x_min", got.x_min, want.x_min);
        if (got.y_min !== want.y_min) report("y_min", got.y_min, want.y_min);
        if (got.x_max !== want.x_max) report("x_max", got.x_max, want.x_max);
        if (got.y_max !== want.y_max) report("y_max", got.y_max, want.y_max);
        if (got.singular !== want.singular)
            report("singular", got.singular, want.singular);
        if (got.saturated !== want.saturated)
            report("saturated", got.saturated, want.saturated);
    endtask
endclass

module tb_inverse_affine_clip_bbox;
    localparam logic signed [31:0] ONE  = 32'sh0001_0000;
    localparam logic signed [31:0] WMAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] WMIN = 32'sh8000_0000;
    localparam int RANDOM_ITEMS = 1300;
    localparam int DRAIN_CYCLES = 60;   // covers the pipeline latency, plus margin

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic signed [31:0] s_m_a = 0, s_m_b = 0, s_m_c = 0, s_m_d = 0, s_m_e = 0, s_m_f = 0;
    logic signed [31:0] s_clip_x_min = 0, s_clip_y_min = 0;
    logic signed [31:0] s_clip_x_max = 0, s_clip_y_max = 0;
    logic m_valid;
    logic m_ready = 0;
    logic signed [31:0] m_user_x_min, m_user_y_min, m_user_x_max, m_user_y_max;
    logic m_singular, m_saturated;

    bbox_scoreboard boxes = new();
    bit quiet_phase = 0;   // when set, neither side idles

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    inverse_affine_clip_bbox dut (
        .aclk, .aresetn, .s_valid, .s_ready,
        .s_m_a, .s_m_b, .s_m_c, .s_m_d, .s_m_e, .s_m_f,
        .s_clip_x_min, .s_clip_y_min, .s_clip_x_max, .s_clip_y_max,
        .m_valid, .m_ready,
        .m_user_x_min, .m_user_y_min, .m_user_x_max, .m_user_y_max,
        .m_singular, .m_saturated
    );

    // Mostly short gaps, a few long ones.
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(99);
        if (quiet_phase || roll < 60) return 0;
        if (roll < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Note inputs and check outputs on values sampled before this edge's updates.
    always @(posedge aclk) begin
        user_box_t got;
        if (aresetn && s_valid && s_ready) begin
            boxes.note_item('{s_m_a, s_m_b, s_m_c, s_m_d, s_m_e, s_m_f,
                              s_clip_x_min, s_clip_y_min, s_clip_x_max, s_clip_y_max});
        end
        if (aresetn && m_valid && m_ready) begin
            got = '{m_user_x_min, m_user_y_min, m_user_x_max, m_user_y_max,
                    m_singular, m_saturated};
            boxes.check_result(got);
        end
    end

    // Stall the result side in bursts.
    int stall_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 0;
        end else if (stall_left > 0) begin
            m_ready <= 0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1;
            stall_left <= idle_len();
        end
    end

    // Present one item and hold it until accepted; leave valid high afterward.
    task automatic send_item(affine_item_t it);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        {s_m_a, s_m_b, s_m_c, s_m_d, s_m_e, s_m_f} <= {it.a, it.b, it.c, it.d, it.e, it.f};
        {s_clip_x_min, s_clip_y_min, s_clip_x_max, s_clip_y_max} <= {it.x0, it.y0, it.x1, it.y1};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic logic signed [31:0] pick_special();
        case ($urandom_range(6))
            0: return 0;
            1: return ONE;
            2: return -ONE;
            3: return WMAX;
            4: return WMIN;
            5: return 1;
            default: return -1;
        endcase
    endfunction

    // Q16.16 value within +-2^span, random fraction.
    function automatic logic signed [31:0] pick_scaled(int span);
        logic signed [31:0] v;
        v = $urandom_range((1 << (span + 16)) - 1);
        return $urandom_range(1) ? -v : v;
    endfunction

    function automatic affine_item_t random_item();
        affine_item_t it;
        int kind;
        kind = $urandom_range(99);
        it = '{$urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom, $urandom};
        if (kind < 45) begin
            // well-scaled matrix and moderate rectangle
            it.a = pick_scaled(3); it.b = pick_scaled(3);
            it.c = pick_scaled(3); it.d = pick_scaled(3);
            it.e = pick_scaled(10); it.f = pick_scaled(10);
            it.x0 = pick_scaled(10); it.y0 = pick_scaled(10);
            it.x1 = pick_scaled(10); it.y1 = pick_scaled(10);
        end else if (kind < 60) begin
            // singular: second column a multiple of the first
            it.a = pick_scaled(8); it.b = pick_scaled(8);
            it.c = ($urandom_range(1) ? 2 : -1) * it.a;
            it.d = ($urandom_range(1) ? 2 : -1) * it.b;
            if (it.c != 2 * it.a && it.c != -it.a) it.c = it.a;
            it.d = (it.c == 2 * it.a) ? 2 * it.b : -it.b;
        end else if (kind < 75) begin
            // tiny determinant drives saturation
            it.a = $urandom_range(1, 300); it.b = $urandom_range(300);
            it.c = $urandom_range(300); it.d = $urandom_range(1, 300);
        end else if (kind < 85) begin
            it.a = pick_special(); it.b = pick_special();
            it.c = pick_special(); it.d = pick_special();
            it.e = pick_special(); it.x1 = pick_special();
        end
        return it;
    endfunction

    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        affine_item_t directed[$];
        int waited;
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        quiet_phase = 1;
        // identity, scale and rotation-like with translation, negation
        directed.push_back('{ONE, 0, 0, ONE, 0, 0, -ONE, -ONE, ONE, ONE});
        directed.push_back('{2 * ONE, 0, 0, ONE / 2, 5 * ONE, -3 * ONE, 0, 0, 10 * ONE, 7 * ONE});
        directed.push_back('{0, ONE, -ONE, 0, ONE, ONE, -4 * ONE, 2, 3 * ONE, 9 * ONE});
        directed.push_back('{-ONE, 0, 0, -ONE, 0, 0, 5, 7, -3, -9});
        // swapped rectangle edges
        directed.push_back('{ONE, ONE / 4, 0, ONE, 0, 0, 8 * ONE, 6 * ONE, -2 * ONE, -ONE});
        // zero determinant: all zero, and a*d == b*c nonzero
        directed.push_back('{0, 0, 0, 0, ONE, ONE, 0, 0, ONE, ONE});
        directed.push_back('{ONE, 2 * ONE, 3 * ONE, 6 * ONE, 0, 0, WMIN, WMIN, WMAX, WMAX});
        // saturation both ways, ties in rounding
        directed.push_back('{1, 0, 0, 1, 0, 0, WMIN, WMIN, WMAX, WMAX});
        directed.push_back('{3, 0, 0, 3, 0, 0, 1, 2, -1, -2});
        directed.push_back('{2 * ONE, 0, 0, 2 * ONE, 0, 0, 1, 3, -1, -3});
        // extreme words
        directed.push_back('{WMAX, WMIN, WMIN, WMAX, WMAX, WMIN, WMIN, WMAX, WMAX, WMIN});
        directed.push_back('{WMIN, WMAX, WMAX, WMIN, WMIN, WMAX, WMAX, WMIN, WMIN, WMAX});
        directed.push_back('{WMIN, 0, 0, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN});
        directed.push_back('{WMAX, 0, 0, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX});
        directed.push_back('{-1, -1, 1, -1, -1, -1, -1, -1, -1, -1});
        foreach (directed[i]) send_item(directed[i]);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 200 == 0) quiet_phase = ($urandom_range(3) == 0);
            send_item(random_item());
        end
        quiet_phase = 0;
        s_valid <= 0;

        waited = 0;
        while (boxes.pending_boxes.size() != 0 && waited < 100000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (boxes.mismatches == 0 && boxes.pending_boxes.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// File: filelist.f
+incdir+src
src/iacb_pkg.sv
src/iacb_front.sv
src/iacb_queue.sv
src/iacb_div.sv
src/iacb_back.sv
src/inverse_affine_clip_bbox.sv
test/tb_inverse_affine_clip_bbox.sv
